// File: hdl/swfb_pkg.sv
// ----------------------------------------------------------------------------
// swfb_pkg: shared types and constants of the sequence window frame buffer
// Command and status codes, widths and field structs of the two channels.
// ----------------------------------------------------------------------------
`default_nettype none
package swfb_pkg;
  localparam int WINDOW_MAX = 16;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int SEQ_W      = 31;
  localparam int LEN_W      = 16;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_DELETE    = 3'd1;
  localparam logic [2:0] CMD_RELEASE   = 3'd2;
  localparam logic [2:0] CMD_LOOKUP    = 3'd3;
  localparam logic [2:0] CMD_OVERWRITE = 3'd4;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_OUTWIN  = 3'd1;
  localparam logic [2:0] ST_PRESENT = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_SLIDE   = 3'd4;
  localparam logic [2:0] ST_RESTART = 3'd5;

  typedef struct packed {
    logic [2:0]       command;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] frame_length;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [LEN_W-1:0] entry_length;
    logic [3:0]       slot_offset;
    logic [SEQ_W-1:0] window_base;
  } res_t;
endpackage
`default_nettype wire

// File: hdl/swfb_cmd_if.sv
// ----------------------------------------------------------------------------
// swfb_cmd_if / swfb_res_if: valid/ready channels of the frame buffer
// One interface per channel with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface swfb_cmd_if import swfb_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swfb_res_if import swfb_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/swfb_ram.sv
// ----------------------------------------------------------------------------
// swfb_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module swfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/sequence_window_frame_buffer.sv
// ----------------------------------------------------------------------------
// sequence_window_frame_buffer: sliding reorder window of frame slots
// Keeps validity and length per slot, keyed by sequence number from a base.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  cmd      | in  | valid/ready  | command, seq_number, frame_length
//  res      | out | valid/ready  | status, entry_length, slot_offset, window_base
//  cfg      | in  | cfg_we       | cfg_data = window_size
//
//  One command at a time. Delete, overwrite and out-of-window commands go
//  from decide to the result; lookups and plain inserts pass through read and
//  answer (read of the length RAM, then answer). Slides and releases scan the
//  window one slot per cycle up to the first valid slot, then compact it
//  through the length RAM. Valid bits sit in flip-flops cleared by reset or by
//  a cfg write, so no clearing pass. A waiting result blocks the next command.
// ----------------------------------------------------------------------------
`default_nettype none
module sequence_window_frame_buffer import swfb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data,
  swfb_cmd_if.sink        cmd,
  swfb_res_if.source      res
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_READ, S_ANSWER, S_SCAN, S_COPY, S_STORE, S_OUT
  } state_t;

  state_t            state;
  logic [4:0]        window_size;
  logic [SEQ_W-1:0]  base_number;
  logic [WINDOW_MAX-1:0] slot_valid;
  cmd_t              cur;
  logic [SEQ_W-1:0]  d;
  logic [IDX_W:0]    w;
  logic [IDX_W:0]    k;     // compaction shift
  logic [IDX_W:0]    ci;    // copy index
  logic              copy_rd;
  res_t              res_q;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [LEN_W-1:0]  ram_wdata, ram_rdata;

  swfb_ram #(.WIDTH(LEN_W), .DEPTH(WINDOW_MAX)) u_len (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Clamp window size.
  always_comb begin
    if (window_size == 5'd0) begin
      w = (IDX_W+1)'(1);
    end else if ({27'd0, window_size} > WINDOW_MAX) begin
      w = (IDX_W+1)'(WINDOW_MAX);
    end else begin
      w = (IDX_W+1)'(window_size);
    end
  end

  logic neg, d_lt_w, d_lt_2w;
  logic [IDX_W-1:0] d_idx;
  assign neg     = d[SEQ_W-1];
  assign d_lt_w  = !neg && (d < {{(SEQ_W-IDX_W-1){1'b0}}, w});
  assign d_lt_2w = !neg && (d < {{(SEQ_W-IDX_W-2){1'b0}}, w, 1'b0});
  assign d_idx   = d[IDX_W-1:0];

  // Read address: the slot at d during a single-slot read, else the copy source.
  logic [IDX_W:0] src;
  assign src       = ci + k;
  assign ram_raddr = (state == S_DECIDE || state == S_READ) ? d_idx : src[IDX_W-1:0];

  // Drop count for slide/release; scan starts there.
  logic [IDX_W:0] drop;
  always_comb begin
    if (cur.command == CMD_INSERT) begin
      drop = (IDX_W+1)'(d[IDX_W:0] + (IDX_W+1)'(1) - w);
    end else if (d_lt_w) begin
      drop = (IDX_W+1)'(d[IDX_W:0] + (IDX_W+1)'(1));
    end else begin
      drop = w;
    end
  end

  // Placement offset after a slide.
  logic [IDX_W:0] slide_off;
  assign slide_off = (IDX_W+1)'(d[IDX_W+1:0] - {1'b0, k});

  assign cmd.ready = (state == S_IDLE) && !cfg_we;
  assign res.valid = (state == S_OUT);
  assign res.data  = res_q;

  always_ff @(posedge clk) begin
    ram_we <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      window_size <= 5'd16;
      base_number <= '0;
      slot_valid  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            window_size <= cfg_data;
            slot_valid  <= '0;
            base_number <= '0;
          end else if (cmd.valid) begin
            cur   <= cmd.data;
            d     <= SEQ_W'(cmd.data.seq_number - base_number);
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // issue RAM read of slot d (address is combinational)
          res_q.status       <= ST_OUTWIN;
          res_q.entry_length <= '0;
          res_q.slot_offset  <= '0;
          res_q.window_base  <= base_number;
          state <= S_OUT;
          case (cur.command)
            CMD_INSERT: begin
              if (neg) begin
                state <= S_OUT;
              end else if (d_lt_w) begin
                state <= S_READ;
              end else if (d_lt_2w) begin
                for (int i = 0; i < WINDOW_MAX; i++) begin
                  if ((IDX_W+1)'(i) < drop) slot_valid[i] <= 1'b0;
                end
                k     <= drop;
                state <= S_SCAN;
              end else begin
                slot_valid    <= WINDOW_MAX'(1);
                ram_we <= 1'b1; ram_waddr <= '0; ram_wdata <= cur.frame_length;
                base_number   <= cur.seq_number;
                res_q.status       <= ST_RESTART;
                res_q.entry_length <= cur.frame_length;
                res_q.window_base  <= cur.seq_number;
              end
            end
            CMD_DELETE: begin
              if (d_lt_w) begin
                slot_valid[d_idx]  <= 1'b0;
                res_q.status       <= ST_DONE;
                res_q.slot_offset  <= 4'(d_idx);
              end
            end
            CMD_RELEASE: begin
              res_q.status <= ST_DONE;
              if (!neg) begin
                for (int i = 0; i < WINDOW_MAX; i++) begin
                  if ((IDX_W+1)'(i) < drop) slot_valid[i] <= 1'b0;
                end
                k     <= drop;
                state <= S_SCAN;
              end
            end
            CMD_LOOKUP: begin
              if (d_lt_w) state <= S_READ;
            end
            CMD_OVERWRITE: begin
              if (d_lt_w) begin
                slot_valid[d_idx] <= 1'b1;
                ram_we <= 1'b1; ram_waddr <= d_idx; ram_wdata <= cur.frame_length;
                res_q.status       <= ST_DONE;
                res_q.entry_length <= cur.frame_length;
                res_q.slot_offset  <= 4'(d_idx);
              end
            end
            default: ;
          endcase
        end
        S_READ: state <= S_ANSWER;  // read data registered
        S_ANSWER: begin
          res_q.slot_offset <= 4'(d_idx);
          if (slot_valid[d_idx]) begin
            res_q.status       <= (cur.command == CMD_INSERT) ? ST_PRESENT : ST_DONE;
            res_q.entry_length <= ram_rdata;
          end else if (cur.command == CMD_INSERT) begin
            slot_valid[d_idx] <= 1'b1;
            ram_we <= 1'b1; ram_waddr <= d_idx; ram_wdata <= cur.frame_length;
            res_q.status       <= ST_DONE;
            res_q.entry_length <= cur.frame_length;
          end else begin
            res_q.status <= ST_EMPTY;
          end
          state <= S_OUT;
        end
        S_SCAN: begin
          // advance k to the first valid slot, one slot per cycle
          if (k < w && !slot_valid[k[IDX_W-1:0]]) begin
            k <= k + (IDX_W+1)'(1);
          end else begin
            ci      <= '0;
            copy_rd <= 1'b0;
            state   <= S_COPY;
          end
        end
        S_COPY: begin
          // read source ci+k, write it to ci in the cycle after
          if (k == '0 || k >= w) begin
            if (k >= w) slot_valid <= '0;
            state <= S_STORE;
          end else if (!copy_rd) begin
            copy_rd <= 1'b1;
          end else begin
            ram_we <= 1'b1; ram_waddr <= ci[IDX_W-1:0]; ram_wdata <= ram_rdata;
            slot_valid[ci[IDX_W-1:0]] <= slot_valid[src[IDX_W-1:0]];
            slot_valid[src[IDX_W-1:0]] <= 1'b0;
            copy_rd <= 1'b0;
            if (src + (IDX_W+1)'(1) >= w) begin
              state <= S_STORE;
            end else begin
              ci <= ci + (IDX_W+1)'(1);
            end
          end
        end
        S_STORE: begin
          if (cur.command == CMD_INSERT) begin
            res_q.status       <= ST_SLIDE;
            res_q.entry_length <= cur.frame_length;
            ram_we <= 1'b1; ram_wdata <= cur.frame_length;
            if (k >= w) begin
              slot_valid[0]     <= 1'b1;
              ram_waddr         <= '0;
              res_q.slot_offset <= '0;
              base_number       <= cur.seq_number;
              res_q.window_base <= cur.seq_number;
            end else begin
              slot_valid[slide_off[IDX_W-1:0]] <= 1'b1;
              ram_waddr         <= slide_off[IDX_W-1:0];
              res_q.slot_offset <= 4'(slide_off[IDX_W-1:0]);
              base_number       <= SEQ_W'(base_number + SEQ_W'(k));
              res_q.window_base <= SEQ_W'(base_number + SEQ_W'(k));
            end
          end else begin
            if (k < w) begin
              base_number       <= SEQ_W'(base_number + SEQ_W'(k));
              res_q.window_base <= SEQ_W'(base_number + SEQ_W'(k));
            end else begin
              base_number       <= SEQ_W'(cur.seq_number + SEQ_W'(1));
              res_q.window_base <= SEQ_W'(cur.seq_number + SEQ_W'(1));
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the result while it waits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !cmd.ready)
    else $error("command taken while result pending");
  a_off: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.status == ST_OUTWIN |->
      res.data.entry_length == '0 && res.data.slot_offset == '0)
    else $error("out of window result carries data");
endmodule
`default_nettype wire
